// ===== hdl/nwt_pkg.sv =====
// Shared types and word codes for the number-to-word-tokens block.
package nwt_pkg;

    // Width of one word code
    localparam int WORD_W = 5;

    // Word codes
    localparam logic [WORD_W-1:0] WORD_EMPTY     = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEEN_BASE = 5'd10;
    localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] WORD_SCALE     = 5'd28;

    // Number of input bits fed through the binary-to-BCD converter
    localparam int BIN_W   = 32;
    localparam int BCD_W   = 40;
    localparam int CNT_W   = 5;

    // Word positions inside one three-digit group
    localparam int SLOTS   = 5;
    localparam int SLOT_W  = 3;
    localparam logic [SLOT_W-1:0] SLOT_HUND_DIGIT = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_HUNDRED    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_TENS       = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_ONES       = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SCALE      = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new input item
        logic conv;   // one double-dabble step
        logic emit;   // scan one word position, load the output if non-empty
        logic zero;   // load the empty marker as the only word
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_pos;     // the offered input value is above zero
        logic conv_done;  // the current conversion step is the final one
        logic word_nz;    // the current word position holds a word
        logic word_last;  // that word is the final one of the number
        logic out_free;   // the output register can take a word this cycle
    } t_sts;

endpackage

// ===== hdl/number_to_word_tokens.sv =====
// Top level of the number-to-word-tokens block.
// Spells a signed 32-bit number as English word codes, largest group first,
// one word per item on the output, the final word flagged by o_last; zero or
// a negative number gives the single empty code. A positive number is taken
// in, passed bit by bit through the binary-to-BCD converter and then scanned
// word position by word position, from the billions group down to the
// final word. A stall on the output holds the scan as well, even on word
// positions that are empty. The next number is taken once the final word
// sits in the output register. Zero or a negative number is taken in and
// loads the empty code once the output register is free.
module number_to_word_tokens (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [31:0]         i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [nwt_pkg::WORD_W-1:0] o_word,
    output logic                       o_last
);
    import nwt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing
    nwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Conversion, word selection and output register
    nwt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_value),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word),
        .o_last  (o_last)
    );

endmodule

// ===== hdl/nwt_ctrl.sv =====
// Controller state machine for the number-to-word-tokens block.
module nwt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  nwt_pkg::t_sts i_sts,
    output nwt_pkg::t_cmd o_cmd
);
    import nwt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_CONV = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // An item is taken only while no number is in progress.
    assign o_stall = (r_state != ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_pos ? ST_CONV : ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (i_sts.out_free) begin
                    o_cmd.zero = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.word_nz && i_sts.word_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/nwt_dp.sv =====
// Datapath: binary-to-BCD converter, word scanner and output register.
module nwt_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [31:0]         i_value,
    input  nwt_pkg::t_cmd              i_cmd,
    output nwt_pkg::t_sts              o_sts,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [nwt_pkg::WORD_W-1:0] o_word,
    output logic                       o_last
);
    import nwt_pkg::*;

    logic [BIN_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_group;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;

    logic [BCD_W-1:0]  adj;
    logic [3:0]        dig_h;
    logic [3:0]        dig_t;
    logic [3:0]        dig_o;
    logic              lower_nz;
    logic              group_nz;
    logic [WORD_W-1:0] words [SLOTS];
    logic [WORD_W-1:0] cur_word;
    logic              rest_nz;

    // Add three to every BCD digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Digits of the current group and whether any lower group is non-zero
    always_comb begin
        dig_h    = 4'd0;
        dig_t    = 4'd0;
        dig_o    = 4'd0;
        lower_nz = 1'b0;
        case (r_group)
            2'd0: begin
                dig_h = r_bcd[11:8];
                dig_t = r_bcd[7:4];
                dig_o = r_bcd[3:0];
            end
            2'd1: begin
                dig_h    = r_bcd[23:20];
                dig_t    = r_bcd[19:16];
                dig_o    = r_bcd[15:12];
                lower_nz = (r_bcd[11:0] != '0);
            end
            2'd2: begin
                dig_h    = r_bcd[35:32];
                dig_t    = r_bcd[31:28];
                dig_o    = r_bcd[27:24];
                lower_nz = (r_bcd[23:0] != '0);
            end
            default: begin
                dig_o    = r_bcd[39:36];
                lower_nz = (r_bcd[35:0] != '0);
            end
        endcase
    end

    // The five possible words of the current group, empty where absent
    always_comb begin
        group_nz = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_o != 4'd0);
        words[SLOT_HUND_DIGIT] = (dig_h != 4'd0) ? {1'b0, dig_h} : WORD_EMPTY;
        words[SLOT_HUNDRED]    = (dig_h != 4'd0) ? WORD_HUNDRED : WORD_EMPTY;
        if (dig_t == 4'd1) begin
            words[SLOT_TENS] = WORD_TEEN_BASE + {1'b0, dig_o};
        end else if (dig_t >= 4'd2) begin
            words[SLOT_TENS] = WORD_TENS_BASE + {1'b0, dig_t};
        end else begin
            words[SLOT_TENS] = WORD_EMPTY;
        end
        words[SLOT_ONES] = ((dig_t != 4'd1) && (dig_o != 4'd0)) ? {1'b0, dig_o}
                                                                 : WORD_EMPTY;
        words[SLOT_SCALE] = ((r_group != 2'd0) && group_nz)
                          ? (WORD_SCALE + {3'b000, r_group}) : WORD_EMPTY;
    end

    // Current word and whether any word follows it within the group
    always_comb begin
        cur_word = words[r_slot];
        rest_nz  = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((SLOT_W'(i) > r_slot) && (words[i] != WORD_EMPTY)) begin
                rest_nz = 1'b1;
            end
        end
    end

    // Status towards the controller
    always_comb begin
        o_sts.in_pos    = (i_value > 32'sd0);
        o_sts.conv_done = (r_cnt == CNT_W'(BIN_W - 1));
        o_sts.word_nz   = (cur_word != WORD_EMPTY);
        o_sts.word_last = !rest_nz && !lower_nz;
        o_sts.out_free  = !r_out_valid || !i_stall;
    end

    // Converter and scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= i_value;
            r_bcd   <= '0;
            r_cnt   <= '0;
            r_group <= 2'd3;
            r_slot  <= SLOT_HUND_DIGIT;
        end else if (i_cmd.conv) begin
            r_bcd <= {adj[BCD_W-2:0], r_bin[BIN_W-1]};
            r_bin <= {r_bin[BIN_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.emit) begin
            if (r_slot == SLOT_SCALE) begin
                r_slot  <= SLOT_HUND_DIGIT;
                r_group <= r_group - 1'b1;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Output register: holds one word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.zero || (i_cmd.emit && o_sts.word_nz)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero) begin
            r_out_word <= WORD_EMPTY;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit && o_sts.word_nz) begin
            r_out_word <= cur_word;
            r_out_last <= o_sts.word_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    assign o_last  = r_out_last;

endmodule

// ===== test/number_to_word_tokens_test.sv =====
// Self-checking testbench for the number-to-word-tokens block.
module number_to_word_tokens_test;
    import nwt_pkg::*;

    localparam int N_RANDOM    = 405;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    // Word codes that the directed rows spell out by hand
    localparam logic [WORD_W-1:0] WORD_ONE      = 5'd1;
    localparam logic [WORD_W-1:0] WORD_NINETEEN = WORD_TEEN_BASE + 5'd9;
    localparam logic [WORD_W-1:0] WORD_BILLION  = WORD_SCALE + 5'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_word_item;

    // One directed row: a number and, where obvious, its spelling (n_typed words)
    typedef struct packed {
        logic [31:0]       value;
        logic [1:0]        n_typed;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } t_spell_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_last;
    logic [WORD_W-1:0]  o_word;

    // Typed spelling that travels alongside the number being offered
    logic [1:0]         drv_n_typed = 2'd0;
    logic [WORD_W-1:0]  drv_w0      = WORD_EMPTY;
    logic [WORD_W-1:0]  drv_w1      = WORD_EMPTY;

    t_word_item pending_words[$];
    t_spell_row directed_rows [0:24];
    int         mismatches  = 0;
    int         idle_cycles = 0;
    int         stall_hold  = 0;
    logic       stall_level = 1'b0;
    int         calm_left   = 0;

    number_to_word_tokens u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word),
        .o_last  (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Spell a number as word codes, largest group first, and queue them.
    function automatic void spell_number(input logic signed [31:0] value);
        logic [WORD_W-1:0] words[$];
        logic [31:0]       rest;
        int                grp [4];
        int                hund;
        int                tail;
        int                k;
        if (value <= 0) begin
            pending_words.push_back('{WORD_EMPTY, 1'b1});
            return;
        end
        rest = value;
        for (k = 0; k < 4; k++) begin
            grp[k] = rest % 1000;
            rest   = rest / 1000;
        end
        for (k = 3; k >= 0; k--) begin
            if (grp[k] == 0)
                continue;
            hund = grp[k] / 100;
            tail = grp[k] % 100;
            if (hund > 0) begin
                words.push_back(WORD_W'(hund));
                words.push_back(WORD_HUNDRED);
            end
            if (tail >= 10 && tail < 20) begin
                words.push_back(WORD_TEEN_BASE + WORD_W'(tail - 10));
            end else begin
                if (tail / 10 >= 2)
                    words.push_back(WORD_TENS_BASE + WORD_W'(tail / 10));
                if (tail % 10 > 0)
                    words.push_back(WORD_W'(tail % 10));
            end
            if (k > 0)
                words.push_back(WORD_SCALE + WORD_W'(k));
        end
        foreach (words[j])
            pending_words.push_back('{words[j], j == words.size() - 1});
    endfunction

    // A three-digit group: often zero or ending in a teen, otherwise anything.
    function automatic int random_group();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return $urandom_range(0, 9) * 100 + $urandom_range(10, 19);
        return $urandom_range(0, 999);
    endfunction

    function automatic logic [31:0] random_number();
        int     pick;
        longint bil;
        longint mil;
        longint total;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return $urandom | 32'h8000_0000;
        if (pick < 10)
            return 32'd0;
        if (pick < 25)
            return $urandom_range(1, 999);
        if (pick < 40)
            return $urandom_range(1000, 999999);
        if (pick < 55)
            return $urandom;
        // Built group by group so that zero groups and teens turn up often
        bil   = $urandom_range(0, 2);
        mil   = (bil == 2) ? $urandom_range(0, 146) : random_group();
        total = bil * 1000000000 + mil * 1000000 + random_group() * 1000 + random_group();
        return total[31:0];
    endfunction

    // Sender gaps: mostly none or short, a few long, and calm stretches.
    function automatic int sender_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            calm_left = $urandom_range(20, 50);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 80)
            return 1;
        if (pick < 93)
            return $urandom_range(2, 5);
        return $urandom_range(10, 40);
    endfunction

    // Offer one number and wait until the block takes the item.
    task automatic send_number(input logic [31:0] value, input logic [1:0] n_typed,
                               input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_value     <= value;
        drv_n_typed <= n_typed;
        drv_w0      <= w0;
        drv_w1      <= w1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Receiver stall: short bursts, occasional long ones and calm stretches.
    always @(negedge i_clk) begin : stall_driver
        int pick;
        if (stall_hold == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                stall_level = 1'b0;
                stall_hold  = $urandom_range(1, 4);
            end else if (pick < 85) begin
                stall_level = 1'b1;
                stall_hold  = $urandom_range(1, 3);
            end else if (pick < 95) begin
                stall_level = 1'b0;
                stall_hold  = $urandom_range(20, 60);
            end else begin
                stall_level = 1'b1;
                stall_hold  = $urandom_range(10, 40);
            end
        end
        stall_hold--;
        i_stall <= stall_level;
    end

    // Input items queue their spelling; output items are checked against it.
    always @(posedge i_clk) begin : word_monitor
        t_word_item want;
        logic       moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            moved = 1'b1;
            if (drv_n_typed == 2'd0) begin
                spell_number(i_value);
            end else begin
                pending_words.push_back('{drv_w0, drv_n_typed == 2'd1});
                if (drv_n_typed == 2'd2)
                    pending_words.push_back('{drv_w1, 1'b1});
            end
        end
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            moved = 1'b1;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word %0d last %0b", o_word, o_last);
            end else begin
                want = pending_words.pop_front();
                if (o_word !== want.word || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word mismatch: expected %0d last %0b, got %0d last %0b",
                                 want.word, want.last, o_word, o_last);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        directed_rows = '{
            '{32'd0,          2'd1, WORD_EMPTY,    WORD_EMPTY},
            '{32'hFFFF_FFFF,  2'd1, WORD_EMPTY,    WORD_EMPTY},
            '{32'h8000_0000,  2'd1, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1,          2'd1, WORD_ONE,      WORD_EMPTY},
            '{32'd19,         2'd1, WORD_NINETEEN, WORD_EMPTY},
            '{32'd1000000000, 2'd2, WORD_ONE,      WORD_BILLION},
            '{32'd9,          2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd10,         2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd20,         2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd21,         2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd99,         2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd100,        2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd101,        2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd110,        2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd999,        2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1000,       2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1001,       2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1000000,    2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1000001,    2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1000100,    2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd2000010,    2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd1010010,    2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd123456789,  2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd2147483646, 2'd0, WORD_EMPTY,    WORD_EMPTY},
            '{32'd2147483647, 2'd0, WORD_EMPTY,    WORD_EMPTY}
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: empty marker cases, extremes and group shapes
        foreach (directed_rows[j])
            send_number(directed_rows[j].value, directed_rows[j].n_typed,
                        directed_rows[j].w0, directed_rows[j].w1);

        // Random numbers, twice pausing until every word has come out
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 4 || k == 3 * N_RANDOM / 4) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_words.size() != 0) @(posedge i_clk);
            end
            send_number(random_number(), 2'd0, WORD_EMPTY, WORD_EMPTY);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
